// ----- rtl/gudt_pkg.sv -----
// Shared types and constants for the greedy unit dispatch timer.
// Holds the command codes, the controller state encoding and fixed field widths.
// No dependencies.
`default_nettype none

package gudt_pkg;

    localparam int TimeW      = 32;  // Q16.16 time word
    localparam int CntW       = 3;   // successor count field
    localparam int IdxW       = 4;   // unit index field on the ports
    localparam int SuccFields = 4;   // successor fields on the input item

    localparam logic [TimeW-1:0] TimeMax = '1;

    localparam logic KindJob   = 1'b0;
    localparam logic KindTotal = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_DISPATCH = 2'd1,
        CMD_READ     = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HOP,
        S_SCAN,
        S_EVAL,
        S_NEXT,
        S_DONE,
        S_READ,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/greedy_unit_dispatch_timer.sv -----
// Greedy unit dispatch timer: top level with the unit memory and its controller.
// Depends on gudt_pkg for command codes, state encoding and field widths.
//
// One transaction at a time. A load writes one unit entry (service time,
// successor list, cleared busy-until and total) and finishes in the cycle it
// is taken; it gives no result. A read goes through S_READ and S_EMIT to the
// output register. A dispatch walks the unit graph from unit 0: each hop
// serves a unit in S_HOP and, unless it is an exit hop or the hop at the
// visit limit, prices its successors in S_SCAN and S_EVAL, where the single
// read port of the unit memory fetches one successor entry per cycle, then
// moves to the cheapest in S_NEXT. The dispatch is accepted in S_IDLE and
// ends with the completion update in S_DONE and the result in S_EMIT. The
// entries of all units sit in one synchronous memory (one read, one write
// per cycle, registered read data); a bit per unit marks whether busy-until
// and total have been written since reset, so reset needs no clearing pass.
// The result sits in an output register, so the next transaction is taken
// while a result waits. Times are unsigned Q16.16 and every sum saturates at
// all ones. A route that would go beyond NUM_UNITS visits stops at its last
// allowed unit and flags o_route_overflow.
`default_nettype none

module greedy_unit_dispatch_timer #(
    parameter int NUM_UNITS      = 16,
    parameter int MAX_SUCCESSORS = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [1:0]                     i_cmd,
    input  wire logic [gudt_pkg::IdxW-1:0]      i_unit_index,
    input  wire logic [gudt_pkg::TimeW-1:0]     i_service_time,
    input  wire logic [gudt_pkg::CntW-1:0]      i_successor_count,
    input  wire logic [gudt_pkg::IdxW-1:0]      i_successor_a,
    input  wire logic [gudt_pkg::IdxW-1:0]      i_successor_b,
    input  wire logic [gudt_pkg::IdxW-1:0]      i_successor_c,
    input  wire logic [gudt_pkg::IdxW-1:0]      i_successor_d,
    input  wire logic [gudt_pkg::TimeW-1:0]     i_arrival_time,

    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_result_kind,
    output logic [gudt_pkg::TimeW-1:0]          o_completion_time,
    output logic [gudt_pkg::TimeW-1:0]          o_factory_span,
    output logic [gudt_pkg::TimeW-1:0]          o_unit_total,
    output logic                                o_route_overflow
);

    localparam int TW        = gudt_pkg::TimeW;
    localparam int CW        = gudt_pkg::CntW;
    localparam int UW        = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int SuccLimit = (MAX_SUCCESSORS < gudt_pkg::SuccFields)
                               ? MAX_SUCCESSORS : gudt_pkg::SuccFields;
    localparam int SW        = SuccLimit * UW;
    localparam int KW        = (SuccLimit > 1) ? $clog2(SuccLimit) : 1;
    localparam int VW        = $clog2(NUM_UNITS + 1);

    localparam logic [UW-1:0] LastUnit   = UW'(NUM_UNITS - 1);
    localparam logic [CW-1:0] CntLimit   = CW'(SuccLimit);
    localparam logic [VW-1:0] VisitLimit = VW'(NUM_UNITS);

    typedef struct packed {
        logic [TW-1:0] svc;
        logic [CW-1:0] cnt;
        logic [SW-1:0] succ;
        logic [TW-1:0] busy;
        logic [TW-1:0] total;
    } t_entry;

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                              input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? gudt_pkg::TimeMax : s[TW-1:0];
    endfunction

    function automatic logic [UW-1:0] clamp_unit(input logic [gudt_pkg::IdxW-1:0] v);
        return (32'(v) >= NUM_UNITS) ? LastUnit : UW'(v);
    endfunction

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    gudt_pkg::t_state r_state, n_state;

    t_entry              r_unit_mem [NUM_UNITS];
    t_entry              r_rd;           // registered read data
    logic                r_rd_live;      // busy/total of the read entry are written
    logic [NUM_UNITS-1:0] r_live;

    logic [UW-1:0]       r_u;
    logic [TW-1:0]       r_t;
    logic [VW-1:0]       r_visits;
    logic [CW-1:0]       r_cnt;
    logic [SW-1:0]       r_succ;
    logic [KW-1:0]       r_k;
    logic [UW-1:0]       r_best;
    logic [TW-1:0]       r_best_cost;
    logic                r_ovf;
    logic                r_kind;
    logic                r_idx_ok;

    logic                r_first_seen;
    logic [TW-1:0]       r_first_arrival;
    logic [TW-1:0]       r_latest;

    logic                r_out_valid;
    logic                r_result_kind;
    logic [TW-1:0]       r_completion_time;
    logic [TW-1:0]       r_factory_span;
    logic [TW-1:0]       r_unit_total;
    logic                r_route_overflow;

    // ---------------------------------------------------------------
    // Datapath terms
    // ---------------------------------------------------------------
    logic                accept;
    logic                out_free;
    logic [UW-1:0]       in_unit;
    logic                in_unit_ok;
    logic [CW-1:0]       in_cnt;
    logic [SW-1:0]       in_succ;
    logic [gudt_pkg::IdxW-1:0] succ_field [gudt_pkg::SuccFields];

    logic [TW-1:0]       busy_eff;
    logic [TW-1:0]       total_eff;
    logic [TW-1:0]       hop_start;
    logic [TW-1:0]       hop_leave;
    logic [VW-1:0]       vis_n;
    logic                hop_exit;
    logic                hop_limit;

    logic [UW-1:0]       cur_succ;
    logic [UW-1:0]       nxt_succ;
    logic [KW-1:0]       k_nxt;
    logic [TW-1:0]       cand_cost;
    logic                cand_take;
    logic                scan_last;

    logic                mem_we;
    logic [UW-1:0]       mem_waddr;
    t_entry              mem_wdata;
    logic [UW-1:0]       rd_addr;

    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_unit    = UW'(i_unit_index);
    assign in_unit_ok = 32'(i_unit_index) < NUM_UNITS;
    assign in_cnt     = (i_successor_count > CntLimit) ? CntLimit : i_successor_count;

    assign succ_field[0] = i_successor_a;
    assign succ_field[1] = i_successor_b;
    assign succ_field[2] = i_successor_c;
    assign succ_field[3] = i_successor_d;

    always_comb begin
        in_succ = '0;
        for (int k = 0; k < SuccLimit; k++) begin
            in_succ[k*UW +: UW] = clamp_unit(succ_field[k]);
        end
    end

    // Service at the current unit: start at the later of arrival and busy-until.
    assign busy_eff  = r_rd_live ? r_rd.busy  : '0;
    assign total_eff = r_rd_live ? r_rd.total : '0;
    assign hop_start = (r_t < busy_eff) ? busy_eff : r_t;
    assign hop_leave = sat_add(hop_start, r_rd.svc);
    assign vis_n     = r_visits + 1'b1;
    assign hop_exit  = (r_rd.cnt == '0);
    assign hop_limit = (vis_n == VisitLimit);

    // Successor pricing: one candidate entry per cycle, first listed wins ties.
    assign k_nxt     = r_k + 1'b1;
    assign cur_succ  = r_succ[r_k * UW +: UW];
    assign nxt_succ  = r_succ[k_nxt * UW +: UW];
    assign cand_cost = sat_add(busy_eff, r_rd.svc);
    assign cand_take = (r_k == '0) || (cand_cost < r_best_cost);
    assign scan_last = ((CW'(r_k) + 1'b1) == r_cnt);

    // ---------------------------------------------------------------
    // Controller: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gudt_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        gudt_pkg::CMD_DISPATCH: n_state = gudt_pkg::S_HOP;
                        gudt_pkg::CMD_READ:     n_state = gudt_pkg::S_READ;
                        default:                n_state = gudt_pkg::S_IDLE;
                    endcase
                end
            end
            gudt_pkg::S_HOP: begin
                n_state = (hop_exit || hop_limit) ? gudt_pkg::S_DONE : gudt_pkg::S_SCAN;
            end
            gudt_pkg::S_SCAN: n_state = gudt_pkg::S_EVAL;
            gudt_pkg::S_EVAL: n_state = scan_last ? gudt_pkg::S_NEXT : gudt_pkg::S_EVAL;
            gudt_pkg::S_NEXT: n_state = gudt_pkg::S_HOP;
            gudt_pkg::S_DONE: n_state = gudt_pkg::S_EMIT;
            gudt_pkg::S_READ: n_state = gudt_pkg::S_EMIT;
            gudt_pkg::S_EMIT: n_state = out_free ? gudt_pkg::S_IDLE : gudt_pkg::S_EMIT;
            default:          n_state = gudt_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Controller: outputs (handshake, memory port)
    // ---------------------------------------------------------------
    always_comb begin
        o_in_stall = (r_state != gudt_pkg::S_IDLE);
        mem_we     = 1'b0;
        mem_waddr  = r_u;
        mem_wdata  = r_rd;
        rd_addr    = r_u;
        unique case (r_state)
            gudt_pkg::S_IDLE: begin
                mem_waddr       = in_unit;
                mem_wdata.svc   = i_service_time;
                mem_wdata.cnt   = in_cnt;
                mem_wdata.succ  = in_succ;
                mem_wdata.busy  = '0;
                mem_wdata.total = '0;
                mem_we          = accept && (i_cmd == gudt_pkg::CMD_LOAD) && in_unit_ok;
                rd_addr         = (i_cmd == gudt_pkg::CMD_DISPATCH) ? '0 : in_unit;
            end
            gudt_pkg::S_HOP: begin
                // Write back busy-until and total of the unit just served.
                mem_we          = 1'b1;
                mem_wdata.busy  = hop_leave;
                mem_wdata.total = sat_add(total_eff, r_rd.svc);
            end
            gudt_pkg::S_SCAN: rd_addr = cur_succ;
            gudt_pkg::S_EVAL: rd_addr = nxt_succ;
            gudt_pkg::S_NEXT: rd_addr = r_best;
            default: begin
                rd_addr = r_u;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Unit memory
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_unit_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_unit_mem[rd_addr];
    end

    // Live bits: busy-until and total read as zero until first written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_rd_live <= 1'b0;
        end else begin
            if (mem_we) begin
                r_live[mem_waddr] <= 1'b1;
            end
            r_rd_live <= r_live[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= gudt_pkg::S_IDLE;
            r_first_seen    <= 1'b0;
            r_first_arrival <= '0;
            r_latest        <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            // Latch the first arrival after reset.
            if (r_state == gudt_pkg::S_IDLE && accept && i_cmd == gudt_pkg::CMD_DISPATCH
                && !r_first_seen) begin
                r_first_seen    <= 1'b1;
                r_first_arrival <= i_arrival_time;
            end

            if (r_state == gudt_pkg::S_DONE && r_t > r_latest) begin
                r_latest <= r_t;
            end

            if (r_state == gudt_pkg::S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Walk registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            gudt_pkg::S_IDLE: begin
                r_u      <= (i_cmd == gudt_pkg::CMD_DISPATCH) ? '0 : in_unit;
                r_t      <= i_arrival_time;
                r_visits <= '0;
                r_ovf    <= 1'b0;
                r_idx_ok <= in_unit_ok;
                r_kind   <= (i_cmd == gudt_pkg::CMD_READ) ? gudt_pkg::KindTotal
                                                          : gudt_pkg::KindJob;
            end
            gudt_pkg::S_HOP: begin
                r_t      <= hop_leave;
                r_visits <= vis_n;
                r_cnt    <= r_rd.cnt;
                r_succ   <= r_rd.succ;
                r_k      <= '0;
                r_ovf    <= !hop_exit && hop_limit;
            end
            gudt_pkg::S_EVAL: begin
                if (cand_take) begin
                    r_best      <= cur_succ;
                    r_best_cost <= cand_cost;
                end
                r_k <= k_nxt;
            end
            gudt_pkg::S_NEXT: begin
                r_u <= r_best;
            end
            gudt_pkg::S_READ: begin
                r_t <= r_idx_ok ? total_eff : '0;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == gudt_pkg::S_EMIT && out_free) begin
            r_result_kind <= r_kind;
            if (r_kind == gudt_pkg::KindTotal) begin
                r_completion_time <= '0;
                r_factory_span    <= '0;
                r_unit_total      <= r_t;
                r_route_overflow  <= 1'b0;
            end else begin
                r_completion_time <= r_t;
                r_factory_span    <= (r_latest >= r_first_arrival)
                                     ? (r_latest - r_first_arrival) : '0;
                r_unit_total      <= '0;
                r_route_overflow  <= r_ovf;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_kind     = r_result_kind;
    assign o_completion_time = r_completion_time;
    assign o_factory_span    = r_factory_span;
    assign o_unit_total      = r_unit_total;
    assign o_route_overflow  = r_route_overflow;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_visit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_visits) <= NUM_UNITS)
        else $error("visit count beyond hop limit");

    a_scan_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gudt_pkg::S_EVAL) |-> (CW'(r_k) < r_cnt))
        else $error("successor scan past the unit's list");

    a_hop_marks_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gudt_pkg::S_HOP) |=> r_live[$past(r_u)])
        else $error("served unit not marked live");

    a_emit_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gudt_pkg::S_EMIT && out_free) |=> r_out_valid)
        else $error("result not presented after emit");

    a_span_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result_kind == gudt_pkg::KindJob) |-> (r_factory_span <= r_latest))
        else $error("factory span exceeds latest completion");

endmodule

`default_nettype wire
